@@ src/gsts_pkg.sv @@
// Shared types, codes and helpers for the gradient stop table sampler.
`default_nettype none
package gsts_pkg;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_SET    = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_SAMPLE = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_IDX = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [9:0] POS_MAX  = 10'd1000;
	localparam logic [3:0] DIV_LAST = 4'd10;
	localparam logic [1:0] CH_LAST  = 2'd3;

	typedef struct packed {
		logic [9:0] r;
		logic [9:0] g;
		logic [9:0] b;
		logic [9:0] a;
		logic [9:0] pos;
	} entry_t;

	typedef enum logic [2:0] {
		P_HOLD, P_ZERO, P_ONE, P_IDX, P_LAST, P_CNT, P_INC, P_DEC
	} ptr_op_t;

	typedef enum logic [1:0] {
		RD_PTR, RD_DN, RD_UP
	} rd_sel_t;

	typedef enum logic [1:0] {
		C_HOLD, C_CLR, C_INC
	} cnt_op_t;

	typedef struct packed {
		logic       latch;
		logic       res_clear;
		logic       res_status;
		logic [1:0] status_val;
		logic       res_found;
		logic       res_rd;
		logic       res_prev;
		logic       res_chan;
		ptr_op_t    ptr_op;
		rd_sel_t    rd_sel;
		logic       wr_rd;
		logic       wr_new;
		cnt_op_t    cnt_op;
		logic       save_prev;
		logic       mul;
		logic       div_init;
		logic       div_step;
		logic [1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       cnt_zero;
		logic       cnt_one;
		logic       full;
		logic       idx_ok;
		logic       ptr_zero;
		logic       ptr_top;
		logic       gt_new;
		logic       lt_new;
		logic       match;
		logic       t_le;
		logic       t_ge;
		logic       dt_zero;
		logic       div_done;
	} sts_t;

	function automatic logic [9:0] chan_of(input entry_t e, input logic [1:0] ch);
		logic [9:0] v;
		case (ch)
			2'd0: v = e.r;
			2'd1: v = e.g;
			2'd2: v = e.b;
			default: v = e.a;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ src/gsts_if.sv @@
// Valid/ready channel interfaces for stop operations and their results.
`default_nettype none
interface gsts_item_if;
	logic              valid;
	logic              ready;
	logic [2:0]        operation;
	logic [4:0]        stop_index;
	logic [9:0]        red_in;
	logic [9:0]        green_in;
	logic [9:0]        blue_in;
	logic [9:0]        alpha_in;
	logic signed [11:0] position_in;

	modport source (output valid, operation, stop_index, red_in, green_in, blue_in,
		alpha_in, position_in, input ready);
	modport sink (input valid, operation, stop_index, red_in, green_in, blue_in,
		alpha_in, position_in, output ready);
endinterface

interface gsts_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [4:0] found_index;
	logic [9:0] red_out;
	logic [9:0] green_out;
	logic [9:0] blue_out;
	logic [9:0] alpha_out;
	logic [5:0] stop_count;

	modport source (output valid, status, found_index, red_out, green_out, blue_out,
		alpha_out, stop_count, input ready);
	modport sink (input valid, status, found_index, red_out, green_out, blue_out,
		alpha_out, stop_count, output ready);
endinterface
`default_nettype wire

@@ src/gradient_stop_table_sampler.sv @@
// Top level of the gradient stop table sampler.
//
//  channel | dir | payload
//  item    | in  | operation, stop_index, red/green/blue/alpha_in, position_in
//  result  | out | status, found_index, red/green/blue/alpha_out, stop_count
//
// One word is in flight at a time; a new word is taken in the cycle after its
// result is delivered. Add and set walk the table stop by stop (hole move),
// and add then scans from the first stop for the match; moves and scan
// together cover the table once. Sample scans the table stop by stop, then
// per channel runs a multiply and an 11-step divider. Reset empties the table.
`default_nettype none
module gradient_stop_table_sampler
	import gsts_pkg::*;
#(
	parameter int MAX_STOPS = 32
) (
	input wire logic     clk,
	input wire logic     arst_n,
	gsts_item_if.sink    item,
	gsts_result_if.source result
);

	cmd_t cmd;
	sts_t sts;

	gsts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(item.valid), .in_ready(item.ready),
		.out_valid(result.valid), .out_ready(result.ready),
		.sts(sts), .cmd(cmd)
	);

	gsts_dp #(.MAX_STOPS(MAX_STOPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.operation(item.operation), .stop_index(item.stop_index),
		.red_in(item.red_in), .green_in(item.green_in),
		.blue_in(item.blue_in), .alpha_in(item.alpha_in),
		.position_in(item.position_in),
		.status(result.status), .found_index(result.found_index),
		.red_out(result.red_out), .green_out(result.green_out),
		.blue_out(result.blue_out), .alpha_out(result.alpha_out),
		.stop_count(result.stop_count)
	);

endmodule
`default_nettype wire

@@ src/gsts_ctrl.sv @@
// Controller state machine sequencing table walks, search and interpolation.
`default_nettype none
module gsts_ctrl
	import gsts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_LCHK, S_LCMP, S_RCHK, S_RCMP, S_PUT, S_FRD, S_FCMP,
		S_RRD, S_RSTORE, S_S0RD, S_S0CMP, S_SLRD, S_SLCMP, S_SRD, S_SCMP,
		S_MUL, S_DINIT, S_DSTEP, S_WCH, S_OUT
	} state_t;

	state_t     state_q, nxt;
	logic [1:0] ch_q, ch_nxt;
	logic       rdy_q, vld_q;
	logic       is_add;

	assign in_ready  = rdy_q;
	assign out_valid = vld_q;
	assign is_add    = (sts.op == OP_ADD);

	always_comb begin
		nxt = state_q;
		ch_nxt = ch_q;
		cmd = '0;
		cmd.ptr_op = P_HOLD;
		cmd.rd_sel = RD_PTR;
		cmd.cnt_op = C_HOLD;
		cmd.ch = ch_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					nxt = S_DISP;
				end
			end
			S_DISP: begin
				cmd.res_clear = 1'b1;
				nxt = S_OUT;
				case (sts.op)
					OP_CLEAR: cmd.cnt_op = C_CLR;
					OP_ADD: begin
						if (sts.full) begin
							cmd.res_status = 1'b1;
							cmd.status_val = ST_FULL;
						end else begin
							cmd.ptr_op = P_CNT;
							nxt = S_LCHK;
						end
					end
					OP_SET: begin
						if (!sts.idx_ok) begin
							cmd.res_status = 1'b1;
							cmd.status_val = ST_BAD_IDX;
						end else begin
							cmd.ptr_op = P_IDX;
							nxt = S_LCHK;
						end
					end
					OP_READ: begin
						if (sts.idx_ok) begin
							cmd.ptr_op = P_IDX;
							nxt = S_RRD;
						end
					end
					OP_SAMPLE: begin
						if (!sts.cnt_zero) begin
							cmd.ptr_op = P_ZERO;
							nxt = S_S0RD;
						end
					end
					default: nxt = S_OUT;
				endcase
			end
			// The pointer marks a hole; neighbors that are out of order move into it.
			S_LCHK: begin
				if (sts.ptr_zero) begin
					nxt = is_add ? S_PUT : S_RCHK;
				end else begin
					cmd.rd_sel = RD_DN;
					nxt = S_LCMP;
				end
			end
			S_LCMP: begin
				if (sts.gt_new) begin
					cmd.wr_rd = 1'b1;
					cmd.ptr_op = P_DEC;
					nxt = S_LCHK;
				end else begin
					nxt = is_add ? S_PUT : S_RCHK;
				end
			end
			S_RCHK: begin
				if (sts.ptr_top) begin
					nxt = S_PUT;
				end else begin
					cmd.rd_sel = RD_UP;
					nxt = S_RCMP;
				end
			end
			S_RCMP: begin
				if (sts.lt_new) begin
					cmd.wr_rd = 1'b1;
					cmd.ptr_op = P_INC;
					nxt = S_RCHK;
				end else begin
					nxt = S_PUT;
				end
			end
			S_PUT: begin
				cmd.wr_new = 1'b1;
				if (is_add) begin
					cmd.cnt_op = C_INC;
					cmd.ptr_op = P_ZERO;
					nxt = S_FRD;
				end else begin
					nxt = S_OUT;
				end
			end
			S_FRD: nxt = S_FCMP;
			S_FCMP: begin
				if (sts.match) begin
					cmd.res_found = 1'b1;
					nxt = S_OUT;
				end else begin
					cmd.ptr_op = P_INC;
					nxt = S_FRD;
				end
			end
			S_RRD: nxt = S_RSTORE;
			S_RSTORE: begin
				cmd.res_rd = 1'b1;
				nxt = S_OUT;
			end
			S_S0RD: nxt = S_S0CMP;
			S_S0CMP: begin
				cmd.save_prev = 1'b1;
				if (sts.cnt_one || sts.t_le) begin
					cmd.res_rd = 1'b1;
					nxt = S_OUT;
				end else begin
					cmd.ptr_op = P_LAST;
					nxt = S_SLRD;
				end
			end
			S_SLRD: nxt = S_SLCMP;
			S_SLCMP: begin
				if (sts.t_ge) begin
					cmd.res_rd = 1'b1;
					nxt = S_OUT;
				end else begin
					cmd.ptr_op = P_ONE;
					nxt = S_SRD;
				end
			end
			S_SRD: nxt = S_SCMP;
			S_SCMP: begin
				if (sts.t_le) begin
					if (sts.dt_zero) begin
						cmd.res_prev = 1'b1;
						nxt = S_OUT;
					end else begin
						ch_nxt = 2'd0;
						nxt = S_MUL;
					end
				end else begin
					cmd.save_prev = 1'b1;
					cmd.ptr_op = P_INC;
					nxt = S_SRD;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				nxt = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				nxt = S_DSTEP;
			end
			S_DSTEP: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) nxt = S_WCH;
			end
			S_WCH: begin
				cmd.res_chan = 1'b1;
				if (ch_q == CH_LAST) begin
					nxt = S_OUT;
				end else begin
					ch_nxt = ch_q + 2'd1;
					nxt = S_MUL;
				end
			end
			S_OUT: begin
				if (out_ready) nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q <= 2'd0;
			rdy_q <= 1'b1;
			vld_q <= 1'b0;
		end else begin
			state_q <= nxt;
			ch_q <= ch_nxt;
			rdy_q <= (nxt == S_IDLE);
			vld_q <= (nxt == S_OUT);
		end
	end

endmodule
`default_nettype wire

@@ src/gsts_dp.sv @@
// Datapath: stop memory, count, pointer, compares, multiplier and divider.
`default_nettype none
module gsts_dp
	import gsts_pkg::*;
#(
	parameter int MAX_STOPS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic [2:0]         operation,
	input  wire logic [4:0]         stop_index,
	input  wire logic [9:0]         red_in,
	input  wire logic [9:0]         green_in,
	input  wire logic [9:0]         blue_in,
	input  wire logic [9:0]         alpha_in,
	input  wire logic signed [11:0] position_in,
	output logic [1:0]              status,
	output logic [4:0]              found_index,
	output logic [9:0]              red_out,
	output logic [9:0]              green_out,
	output logic [9:0]              blue_out,
	output logic [9:0]              alpha_out,
	output logic [5:0]              stop_count
);

	localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int CW = $clog2(MAX_STOPS + 1);
	localparam int XW = 16;

	entry_t            stops_q [MAX_STOPS];
	entry_t            rd_q, prev_q, new_q;
	logic [2:0]        op_q;
	logic [4:0]        idx_q;
	logic signed [11:0] t_q;
	logic [CW-1:0]     cnt_q, cnt_m1;
	logic [IW-1:0]     ptr_q, rd_addr;
	logic [19:0]       p0_q, p1_q;
	logic [11:0]       rem_q, trial;
	logic [10:0]       numer_q, dvsr;
	logic [3:0]        dcnt_q;
	logic [1:0]        res_status_q;
	logic [4:0]        res_found_q;
	logic [3:0][9:0]   res_chan_q;
	logic [9:0]        pos_cl, dt, off, c_l, c_h;
	logic [11:0]       off_w;
	logic signed [11:0] rd_pos_s;
	logic [20:0]       sum_p;
	logic [21:0]       nfull;
	logic              ge;
	logic [XW-1:0]     idx_x, cnt_x, ptr_x;

	assign cnt_m1   = cnt_q - CW'(1);
	assign idx_x    = XW'(idx_q);
	assign cnt_x    = XW'(cnt_q);
	assign ptr_x    = XW'(ptr_q);
	assign rd_pos_s = $signed({2'b00, rd_q.pos});

	always_comb begin
		if (position_in < 12'sd0) pos_cl = 10'd0;
		else if (position_in > $signed({2'b00, POS_MAX})) pos_cl = POS_MAX;
		else pos_cl = position_in[9:0];
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_DN: rd_addr = ptr_q - IW'(1);
			RD_UP: rd_addr = ptr_q + IW'(1);
			default: rd_addr = ptr_q;
		endcase
	end

	// Segment arithmetic: left stop in prev_q, right stop in rd_q.
	assign dt    = rd_q.pos - prev_q.pos;
	assign off_w = t_q - $signed({2'b00, prev_q.pos});
	assign off   = off_w[9:0];
	assign c_l   = chan_of(prev_q, cmd.ch);
	assign c_h   = chan_of(rd_q, cmd.ch);
	assign sum_p = {1'b0, p0_q} + {1'b0, p1_q};
	assign nfull = {sum_p, 1'b0} + {12'b0, dt};
	assign dvsr  = {dt, 1'b0};
	assign trial = {rem_q[10:0], numer_q[10]};
	assign ge    = (trial >= {1'b0, dvsr});

	assign sts.op       = op_q;
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.cnt_one  = (cnt_q == CW'(1));
	assign sts.full     = (cnt_q == CW'(MAX_STOPS));
	assign sts.idx_ok   = (idx_x < cnt_x);
	assign sts.ptr_zero = (ptr_q == '0);
	assign sts.ptr_top  = (CW'(ptr_q) == cnt_m1);
	assign sts.gt_new   = (rd_q.pos > new_q.pos);
	assign sts.lt_new   = (rd_q.pos < new_q.pos);
	assign sts.match    = (rd_q.pos == new_q.pos) && (rd_q.r == new_q.r);
	assign sts.t_le     = (t_q <= rd_pos_s);
	assign sts.t_ge     = (t_q >= rd_pos_s);
	assign sts.dt_zero  = (dt == '0);
	assign sts.div_done = (dcnt_q == DIV_LAST);

	always_ff @(posedge clk) begin
		rd_q <= stops_q[rd_addr];
		if (cmd.wr_new) stops_q[ptr_q] <= new_q;
		else if (cmd.wr_rd) stops_q[ptr_q] <= rd_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= operation;
			idx_q <= stop_index;
			t_q <= position_in;
			new_q <= '{r: red_in, g: green_in, b: blue_in, a: alpha_in, pos: pos_cl};
		end
		if (cmd.save_prev) prev_q <= rd_q;
		if (cmd.mul) begin
			p0_q <= c_l * (dt - off);
			p1_q <= c_h * off;
		end
		// The quotient is below 2048, so the top numerator bits seed the remainder.
		if (cmd.div_init) begin
			rem_q <= {1'b0, nfull[21:11]};
			numer_q <= nfull[10:0];
			dcnt_q <= 4'd0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? (trial - {1'b0, dvsr}) : trial;
			numer_q <= {numer_q[9:0], ge};
			dcnt_q <= dcnt_q + 4'd1;
		end
		if (cmd.res_clear) begin
			res_status_q <= cmd.res_status ? cmd.status_val : ST_OK;
			res_found_q <= 5'd0;
			res_chan_q <= '0;
		end else if (cmd.res_status) begin
			res_status_q <= cmd.status_val;
		end
		if (cmd.res_found) res_found_q <= ptr_x[4:0];
		if (cmd.res_rd) res_chan_q <= {rd_q.a, rd_q.b, rd_q.g, rd_q.r};
		if (cmd.res_prev) res_chan_q <= {prev_q.a, prev_q.b, prev_q.g, prev_q.r};
		if (cmd.res_chan) res_chan_q[cmd.ch] <= numer_q[9:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else begin
			case (cmd.cnt_op)
				C_CLR: cnt_q <= '0;
				C_INC: cnt_q <= cnt_q + CW'(1);
				default: cnt_q <= cnt_q;
			endcase
			case (cmd.ptr_op)
				P_ZERO: ptr_q <= '0;
				P_ONE: ptr_q <= IW'(1);
				P_IDX: ptr_q <= idx_x[IW-1:0];
				P_LAST: ptr_q <= cnt_m1[IW-1:0];
				P_CNT: ptr_q <= cnt_q[IW-1:0];
				P_INC: ptr_q <= ptr_q + IW'(1);
				P_DEC: ptr_q <= ptr_q - IW'(1);
				default: ptr_q <= ptr_q;
			endcase
		end
	end

	assign status      = res_status_q;
	assign found_index = res_found_q;
	assign red_out     = res_chan_q[0];
	assign green_out   = res_chan_q[1];
	assign blue_out    = res_chan_q[2];
	assign alpha_out   = res_chan_q[3];
	assign stop_count  = cnt_x[5:0];

endmodule
`default_nettype wire

@@ src/gsts_chk.sv @@
// Port-level checker for the gradient stop table sampler and its bind.
`default_nettype none
module gsts_chk
	import gsts_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] status,
	input wire logic [4:0] found_index
);

	// A waiting result word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped before it was taken");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while a word is in flight");

	a_free_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("not ready after result delivered");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("ready while a result is pending");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_BAD_IDX) |-> found_index == 5'd0)
		else $error("failed op reports a found index");

endmodule

bind gradient_stop_table_sampler gsts_chk u_gsts_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(item.valid), .in_ready(item.ready),
	.out_valid(result.valid), .out_ready(result.ready),
	.status(result.status), .found_index(result.found_index)
);
`default_nettype wire

@@ verif/gsts_checker.sv @@
// Checker for the gradient stop table sampler: predicts each result and compares it.
`default_nettype none
module gsts_checker
	import gsts_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	gsts_item_if     item,
	gsts_result_if   result,
	output int       failures,
	output int       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 32;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] found_index;
		logic [9:0] red;
		logic [9:0] green;
		logic [9:0] blue;
		logic [9:0] alpha;
		logic [5:0] stop_count;
	} answer_t;

	entry_t  ramp [TABLE_DEPTH];
	int      held;
	answer_t expected_answers [$];

	assign pending = expected_answers.size();

	// Stable insertion sort by position.
	function automatic void sort_ramp();
		entry_t key;
		int j;
		for (int i = 1; i < held; i++) begin
			key = ramp[i];
			j = i - 1;
			while (j >= 0 && ramp[j].pos > key.pos) begin
				ramp[j + 1] = ramp[j];
				j--;
			end
			ramp[j + 1] = key;
		end
	endfunction

	function automatic entry_t stop_from_word();
		entry_t s;
		int p;
		p = item.position_in;
		if (p < 0) p = 0;
		if (p > 1000) p = 1000;
		s.r = item.red_in;
		s.g = item.green_in;
		s.b = item.blue_in;
		s.a = item.alpha_in;
		s.pos = p[9:0];
		return s;
	endfunction

	function automatic logic [9:0] lerp_channel(input logic [9:0] c0, input logic [9:0] c1,
		input longint off, input longint dt);
		longint num;
		longint q;
		num = longint'(c0) * dt + (longint'(c1) - longint'(c0)) * off;
		if (num < 0) num = 0;
		q = (2 * num + dt) / (2 * dt);
		return q[9:0];
	endfunction

	function automatic void put_channels(ref answer_t ans, input entry_t e);
		ans.red = e.r;
		ans.green = e.g;
		ans.blue = e.b;
		ans.alpha = e.a;
	endfunction

	function automatic answer_t predict_answer();
		answer_t ans;
		entry_t s, lo, hi;
		int t;
		longint dt;
		bit done;
		ans = '0;
		case (item.operation)
			OP_CLEAR: held = 0;
			OP_ADD: begin
				if (held >= TABLE_DEPTH) begin
					ans.status = ST_FULL;
				end else begin
					s = stop_from_word();
					ans.found_index = held[4:0];
					ramp[held] = s;
					held++;
					sort_ramp();
					for (int i = 0; i < held; i++) begin
						if (ramp[i].pos == s.pos && ramp[i].r == s.r) begin
							ans.found_index = i[4:0];
							break;
						end
					end
				end
			end
			OP_SET: begin
				if (item.stop_index >= held) begin
					ans.status = ST_BAD_IDX;
				end else begin
					ramp[item.stop_index] = stop_from_word();
					sort_ramp();
				end
			end
			OP_READ: begin
				if (item.stop_index < held) put_channels(ans, ramp[item.stop_index]);
			end
			OP_SAMPLE: begin
				if (held > 0) begin
					t = item.position_in;
					if (held == 1 || t <= int'(ramp[0].pos)) begin
						put_channels(ans, ramp[0]);
					end else if (t >= int'(ramp[held - 1].pos)) begin
						put_channels(ans, ramp[held - 1]);
					end else begin
						done = 0;
						for (int i = 0; i + 1 < held && !done; i++) begin
							lo = ramp[i];
							hi = ramp[i + 1];
							if (t >= int'(lo.pos) && t <= int'(hi.pos)) begin
								dt = longint'(hi.pos) - longint'(lo.pos);
								if (dt == 0) begin
									put_channels(ans, lo);
								end else begin
									ans.red = lerp_channel(lo.r, hi.r, t - lo.pos, dt);
									ans.green = lerp_channel(lo.g, hi.g, t - lo.pos, dt);
									ans.blue = lerp_channel(lo.b, hi.b, t - lo.pos, dt);
									ans.alpha = lerp_channel(lo.a, hi.a, t - lo.pos, dt);
								end
								done = 1;
							end
						end
						if (!done) put_channels(ans, ramp[held - 1]);
					end
				end
			end
			default: ;
		endcase
		ans.stop_count = held[5:0];
		return ans;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failures++;
		end
	endtask

	initial begin
		failures = 0;
		held = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			held = 0;
			expected_answers.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: result word with nothing expected", $time);
					failures++;
				end else begin
					want = expected_answers.pop_front();
					compare_field("status", want.status, result.status);
					compare_field("found_index", want.found_index, result.found_index);
					compare_field("red_out", want.red, result.red_out);
					compare_field("green_out", want.green, result.green_out);
					compare_field("blue_out", want.blue, result.blue_out);
					compare_field("alpha_out", want.alpha, result.alpha_out);
					compare_field("stop_count", want.stop_count, result.stop_count);
				end
			end
			if (item.valid && item.ready) expected_answers.push_back(predict_answer());
		end
	end
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench top: drives operation words into the sampler and gives the verdict.
`default_nettype none
module tb_top
	import gsts_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_WORDS = 800;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   quiet_cycles;
	bit   no_idle;

	gsts_item_if   item ();
	gsts_result_if result ();

	gradient_stop_table_sampler uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	gsts_checker checker_inst (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.result   (result),
		.failures (failures),
		.pending  (pending)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		item.valid = 0;
		item.operation = OP_CLEAR;
		item.stop_index = '0;
		item.red_in = '0;
		item.green_in = '0;
		item.blue_in = '0;
		item.alpha_in = '0;
		item.position_in = '0;
		result.ready = 0;
	end

	always @(posedge clk) begin
		result.ready <= no_idle || ($urandom_range(99) >= 19);
	end

	// Ends the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(input logic [2:0] op, input logic [4:0] idx,
		input logic [9:0] r, input logic [9:0] g, input logic [9:0] b,
		input logic [9:0] a, input logic signed [11:0] pos);
		if (!no_idle && $urandom_range(99) < 19) begin
			item.valid <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		item.valid <= 1;
		item.operation <= op;
		item.stop_index <= idx;
		item.red_in <= r;
		item.green_in <= g;
		item.blue_in <= b;
		item.alpha_in <= a;
		item.position_in <= pos;
		do @(posedge clk); while (!item.ready);
	endtask

	function automatic logic [9:0] pick_channel();
		return ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1000));
	endfunction

	function automatic logic signed [11:0] pick_position();
		case ($urandom_range(9))
			0: return 12'($urandom);
			1, 2, 3: return 12'($urandom_range(10) * 100);
			default: return 12'($urandom_range(1000));
		endcase
	endfunction

	initial begin
		int roll;
		logic [2:0] op;
		quiet_cycles = 0;
		no_idle = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_word(OP_SAMPLE, 0, 0, 0, 0, 0, 500);
		send_word(OP_READ, 0, 0, 0, 0, 0, 0);
		send_word(OP_SET, 0, 5, 5, 5, 5, 5);
		send_word(OP_ADD, 0, 10'd1023, 0, 10'd1023, 0, -12'sd2048);
		send_word(OP_SAMPLE, 0, 0, 0, 0, 0, 700);
		send_word(OP_ADD, 0, 0, 10'd1023, 0, 10'd1023, 12'sd2047);
		send_word(OP_ADD, 0, 300, 400, 500, 600, 400);
		send_word(OP_ADD, 0, 900, 100, 50, 1000, 400);
		send_word(OP_ADD, 0, 300, 1, 2, 3, 400);
		send_word(OP_SAMPLE, 0, 0, 0, 0, 0, -12'sd2048);
		send_word(OP_SAMPLE, 0, 0, 0, 0, 0, 0);
		send_word(OP_SAMPLE, 0, 0, 0, 0, 0, 1000);
		send_word(OP_SAMPLE, 0, 0, 0, 0, 0, 12'sd2047);
		send_word(OP_SAMPLE, 0, 0, 0, 0, 0, 400);
		send_word(OP_SAMPLE, 0, 0, 0, 0, 0, 333);
		send_word(OP_SAMPLE, 0, 0, 0, 0, 0, 777);
		send_word(OP_READ, 2, 0, 0, 0, 0, 0);
		send_word(OP_READ, 31, 0, 0, 0, 0, 0);
		send_word(OP_SET, 1, 1000, 1000, 1000, 1000, 1000);
		send_word(OP_SET, 5, 1, 1, 1, 1, 1);
		send_word(3'd5, 0, 0, 0, 0, 0, 0);
		send_word(3'd6, 0, 0, 0, 0, 0, 0);
		send_word(3'd7, 31, 10'd1023, 10'd1023, 10'd1023, 10'd1023, -12'sd1);
		send_word(OP_CLEAR, 0, 0, 0, 0, 0, 0);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			no_idle = (n >= 300 && n < 450);
			roll = $urandom_range(99);
			if (roll < 2) op = OP_CLEAR;
			else if (roll < 40) op = OP_ADD;
			else if (roll < 52) op = OP_SET;
			else if (roll < 62) op = OP_READ;
			else if (roll < 97) op = OP_SAMPLE;
			else op = 3'($urandom_range(7, 5));
			send_word(op, 5'($urandom_range(31) >> $urandom_range(2)), pick_channel(),
				pick_channel(), pick_channel(), pick_channel(), pick_position());
		end
		item.valid <= 0;
		no_idle = 0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (failures == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
src/gsts_pkg.sv
src/gsts_if.sv
src/gsts_ctrl.sv
src/gsts_dp.sv
src/gradient_stop_table_sampler.sv
src/gsts_chk.sv
verif/gsts_checker.sv
verif/tb_top.sv
